>>> design/stepper_homing_sequencer_top_macros.svh
// ---------------------------------------------------------------------------
// Stepper homing sequencer assertion macros
// Shared property forms for the sequencer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef STEPPER_HOMING_SEQUENCER_TOP_MACROS_SVH
`define STEPPER_HOMING_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SHS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/shs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper homing sequencer package
// Types, widths, codes and the half-step coil table shared by the sequencer.
// ---------------------------------------------------------------------------
package shs_pkg;

    localparam int CAL_RUNS_DEF      = 3;
    localparam int SLOTS_PER_REV_DEF = 8;

    localparam int COIL_W       = 4;
    localparam int PAT_W        = 3;
    localparam int SLOT_CNT_W   = 8;
    localparam int REV_W        = 16;
    localparam int RUN_STEPS_W  = 16;
    localparam int TOTAL_W      = 19;
    localparam int STEPS_LEFT_W = 24;
    localparam int REV_MAX      = 65535;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam logic [REV_W-1:0] INDEX_OFFSET_RST = 16'd150;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_CAL     = 2'd1,
        KIND_REV_CAL = 2'd2,
        KIND_RUN     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ALIGN_HI = 3'd1,
        PH_ALIGN_LO = 3'd2,
        PH_RUN_HI   = 3'd3,
        PH_RUN_LO   = 3'd4,
        PH_EXTRA    = 3'd5,
        PH_BACK     = 3'd6,
        PH_MOVE     = 3'd7
    } phase_t;

    typedef struct packed {
        kind_t                   kind;
        logic                    sensor;
        logic [SLOT_CNT_W-1:0]   slots;
        logic [SLOT_CNT_W-1:0]   pill_count;
        logic [REV_W-1:0]        rev_steps;
        logic [REV_W-1:0]        rev_slot;
    } item_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic              stepped;
        logic              busy_res;
        logic              is_calibrated;
        logic [REV_W-1:0]  rev_count;
        logic              refused;
    } result_t;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PAT_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h1;
        endcase
        return pat;
    endfunction

endpackage

>>> design/shs_in_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequencer input stage
// Input register for one item; also precomputes steps per slot for reverse
// calibrate so the core needs a single multiply per path.
// ---------------------------------------------------------------------------
module shs_in_stage #(
    parameter int SLOTS_PER_REV = shs_pkg::SLOTS_PER_REV_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [shs_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [shs_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                           advance,
    output logic                           item_valid,
    output shs_pkg::item_t                 item
);
    import shs_pkg::*;

    // Exact floor division by a constant through a rounded-up reciprocal.
    localparam int SLOT_SHIFT = REV_W + $clog2(SLOTS_PER_REV);
    localparam int SLOT_MUL_W = SLOT_SHIFT + 1;
    localparam int SLOT_PROD_W = REV_W + SLOT_MUL_W;
    localparam logic [SLOT_MUL_W-1:0] SLOT_MUL =
        SLOT_MUL_W'(((longint'(1) << SLOT_SHIFT) + SLOTS_PER_REV - 1) / SLOTS_PER_REV);

    logic                    valid_reg;
    logic                    valid_next;
    item_t                   item_reg;
    item_t                   item_next;
    logic                    take;
    logic [REV_W-1:0]        rev_in;
    logic [SLOT_PROD_W-1:0]  slot_prod;

    assign s_tready   = !valid_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    assign rev_in    = s_tdata[32:17];
    assign slot_prod = SLOT_PROD_W'(rev_in) * SLOT_PROD_W'(SLOT_MUL);

    always_comb
    begin
        item_next.kind       = kind_t'(s_tuser);
        item_next.sensor     = s_tdata[0];
        item_next.slots      = s_tdata[8:1];
        item_next.pill_count = s_tdata[16:9];
        item_next.rev_steps  = rev_in;
        item_next.rev_slot   = slot_prod[SLOT_SHIFT +: REV_W];
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> design/shs_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequencer core
// Phase state machine, step counters and coil pattern; resolves one item
// per cycle while advance is high and produces its result.
// ---------------------------------------------------------------------------
module shs_core #(
    parameter int CAL_RUNS      = shs_pkg::CAL_RUNS_DEF,
    parameter int SLOTS_PER_REV = shs_pkg::SLOTS_PER_REV_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  shs_pkg::item_t             item,
    input  logic [shs_pkg::REV_W-1:0]  index_offset,
    output shs_pkg::result_t           res
);
    import shs_pkg::*;

    `include "stepper_homing_sequencer_top_macros.svh"

    localparam int IDX_W   = $clog2(CAL_RUNS);
    localparam int AVG_DIV = CAL_RUNS - 1;

    // Average of the counted runs: floor(total / AVG_DIV) by reciprocal.
    localparam int AVG_SHIFT  = TOTAL_W + $clog2(AVG_DIV);
    localparam int AVG_MUL_W  = AVG_SHIFT + 1;
    localparam int AVG_PROD_W = TOTAL_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'(((longint'(1) << AVG_SHIFT) + AVG_DIV - 1) / AVG_DIV);

    // Steps per slot straight from the total, in parallel with the average.
    localparam int SPS_DIV    = AVG_DIV * SLOTS_PER_REV;
    localparam int SPS_SHIFT  = TOTAL_W + $clog2(SPS_DIV);
    localparam int SPS_MUL_W  = SPS_SHIFT + 1;
    localparam int SPS_PROD_W = TOTAL_W + SPS_MUL_W;
    localparam logic [SPS_MUL_W-1:0] SPS_MUL =
        SPS_MUL_W'(((longint'(1) << SPS_SHIFT) + SPS_DIV - 1) / SPS_DIV);
    localparam logic [REV_W-1:0] SAT_SLOT = REV_W'(REV_MAX / SLOTS_PER_REV);
    localparam logic [IDX_W-1:0] LAST_RUN = IDX_W'(CAL_RUNS - 1);

    phase_t                   phase_reg, phase_next;
    logic [PAT_W-1:0]         pattern_reg, pattern_next;
    logic [COIL_W-1:0]        coil_reg, coil_next;
    logic [IDX_W-1:0]         run_index_reg, run_index_next;
    logic [RUN_STEPS_W-1:0]   run_steps_reg, run_steps_next;
    logic [TOTAL_W-1:0]       run_total_reg, run_total_next;
    logic [STEPS_LEFT_W-1:0]  steps_left_reg, steps_left_next;
    logic [REV_W-1:0]         rev_steps_reg, rev_steps_next;
    logic [REV_W-1:0]         slot_size_reg, slot_size_next;
    logic [REV_W-1:0]         pend_slot_reg, pend_slot_next;
    logic                     done_reg, done_next;

    logic                     step_fwd;
    logic                     step_bwd;
    logic                     zero_pat;
    logic                     refused;
    logic                     sl_nz;
    logic [STEPS_LEFT_W-1:0]  sl_dec;
    logic [RUN_STEPS_W-1:0]   steps_inc;
    logic [TOTAL_W:0]         total_sum;
    logic [TOTAL_W-1:0]       total_new;
    logic                     last_run;
    logic [AVG_PROD_W-1:0]    avg_prod;
    logic [TOTAL_W-1:0]       avg_quot;
    logic [REV_W-1:0]         avg_sat;
    logic [SPS_PROD_W-1:0]    sps_prod;
    logic [TOTAL_W-1:0]       sps_quot;
    logic [REV_W-1:0]         slot_from_avg;
    logic                     extra_due;
    logic [REV_W-1:0]         extra_m1;
    logic [STEPS_LEFT_W-1:0]  rev_cmd_steps;
    logic [STEPS_LEFT_W-1:0]  run_cmd_steps;

    assign sl_nz     = |steps_left_reg;
    assign sl_dec    = steps_left_reg - STEPS_LEFT_W'(1);
    assign steps_inc = (&run_steps_reg) ? run_steps_reg : run_steps_reg + RUN_STEPS_W'(1);
    assign last_run  = run_index_reg >= LAST_RUN;

    // The first run only aligns the count; later runs add in with saturation.
    assign total_sum = {1'b0, run_total_reg} + (TOTAL_W + 1)'(run_steps_reg);
    always_comb
    begin
        if (run_index_reg == '0)
        begin
            total_new = run_total_reg;
        end
        else if (total_sum[TOTAL_W])
        begin
            total_new = '1;
        end
        else
        begin
            total_new = total_sum[TOTAL_W-1:0];
        end
    end

    assign avg_prod = AVG_PROD_W'(total_new) * AVG_PROD_W'(AVG_MUL);
    assign avg_quot = avg_prod[AVG_SHIFT +: TOTAL_W];
    assign avg_sat  = (|avg_quot[TOTAL_W-1:REV_W]) ? '1 : avg_quot[REV_W-1:0];

    assign sps_prod      = SPS_PROD_W'(total_new) * SPS_PROD_W'(SPS_MUL);
    assign sps_quot      = sps_prod[SPS_SHIFT +: TOTAL_W];
    assign slot_from_avg = (|avg_quot[TOTAL_W-1:REV_W]) ? SAT_SLOT : sps_quot[REV_W-1:0];

    assign extra_due = avg_sat > index_offset;
    assign extra_m1  = avg_sat - index_offset - REV_W'(1);

    assign rev_cmd_steps = STEPS_LEFT_W'(item.rev_slot) * STEPS_LEFT_W'(item.pill_count);
    assign run_cmd_steps = STEPS_LEFT_W'(slot_size_reg) * STEPS_LEFT_W'(item.slots);

    // Next phase. A failed wait falls through to the next phase with the
    // same sensor sample, so the target here is where the tick settles.
    always_comb
    begin
        phase_next = phase_reg;
        if (item.kind != KIND_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                case (item.kind)
                    KIND_CAL:     phase_next = PH_ALIGN_HI;
                    KIND_REV_CAL: phase_next = PH_BACK;
                    KIND_RUN:     phase_next = done_reg ? PH_MOVE : PH_IDLE;
                    default:      phase_next = PH_IDLE;
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_ALIGN_HI: phase_next = item.sensor ? PH_ALIGN_HI : PH_ALIGN_LO;
                PH_ALIGN_LO: phase_next = item.sensor ? PH_RUN_HI : PH_ALIGN_LO;
                PH_RUN_HI:   phase_next = item.sensor ? PH_RUN_HI : PH_RUN_LO;
                PH_RUN_LO:
                begin
                    if (!item.sensor)
                    begin
                        phase_next = PH_RUN_LO;
                    end
                    else if (last_run)
                    begin
                        phase_next = extra_due ? PH_EXTRA : PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_RUN_HI;
                    end
                end
                PH_EXTRA:    phase_next = sl_nz ? PH_EXTRA : PH_IDLE;
                PH_BACK:
                begin
                    if (item.sensor)
                    begin
                        phase_next = PH_BACK;
                    end
                    else
                    begin
                        phase_next = sl_nz ? PH_MOVE : PH_IDLE;
                    end
                end
                PH_MOVE:     phase_next = sl_nz ? PH_MOVE : PH_IDLE;
                default:     phase_next = PH_IDLE;
            endcase
        end
    end

    // Counters, stepping and result flags.
    always_comb
    begin
        run_index_next  = run_index_reg;
        run_steps_next  = run_steps_reg;
        run_total_next  = run_total_reg;
        steps_left_next = steps_left_reg;
        rev_steps_next  = rev_steps_reg;
        slot_size_next  = slot_size_reg;
        pend_slot_next  = pend_slot_reg;
        done_next       = done_reg;
        step_fwd        = 1'b0;
        step_bwd        = 1'b0;
        zero_pat        = 1'b0;
        refused         = 1'b0;
        if (item.kind != KIND_TICK)
        begin
            if (phase_reg == PH_IDLE)
            begin
                case (item.kind)
                    KIND_CAL:
                    begin
                        run_index_next = '0;
                        run_steps_next = '0;
                        run_total_next = '0;
                    end
                    KIND_REV_CAL:
                    begin
                        run_total_next  = TOTAL_W'(item.rev_steps);
                        pend_slot_next  = item.rev_slot;
                        steps_left_next = rev_cmd_steps;
                    end
                    KIND_RUN:
                    begin
                        if (done_reg)
                        begin
                            steps_left_next = run_cmd_steps;
                        end
                        else
                        begin
                            refused = 1'b1;
                        end
                    end
                    default:
                    begin
                        refused = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_ALIGN_HI:
                begin
                    step_fwd = 1'b1;
                end
                PH_ALIGN_LO:
                begin
                    step_fwd = 1'b1;
                    if (item.sensor)
                    begin
                        run_steps_next = steps_inc;
                    end
                end
                PH_RUN_HI:
                begin
                    step_fwd       = 1'b1;
                    run_steps_next = steps_inc;
                end
                PH_RUN_LO:
                begin
                    if (!item.sensor)
                    begin
                        step_fwd       = 1'b1;
                        run_steps_next = steps_inc;
                    end
                    else
                    begin
                        run_total_next = total_new;
                        if (last_run)
                        begin
                            rev_steps_next = avg_sat;
                            slot_size_next = slot_from_avg;
                            run_index_next = '0;
                            run_steps_next = '0;
                            if (extra_due)
                            begin
                                step_fwd        = 1'b1;
                                steps_left_next = STEPS_LEFT_W'(extra_m1);
                            end
                            else
                            begin
                                zero_pat  = 1'b1;
                                done_next = 1'b1;
                            end
                        end
                        else
                        begin
                            // The new high run starts and counts its first step.
                            run_index_next = run_index_reg + IDX_W'(1);
                            run_steps_next = RUN_STEPS_W'(1);
                            step_fwd       = 1'b1;
                        end
                    end
                end
                PH_EXTRA:
                begin
                    if (sl_nz)
                    begin
                        step_fwd        = 1'b1;
                        steps_left_next = sl_dec;
                    end
                    else
                    begin
                        zero_pat  = 1'b1;
                        done_next = 1'b1;
                    end
                end
                PH_BACK:
                begin
                    if (item.sensor)
                    begin
                        step_bwd = 1'b1;
                    end
                    else
                    begin
                        rev_steps_next = run_total_reg[REV_W-1:0];
                        slot_size_next = pend_slot_reg;
                        run_total_next = '0;
                        if (sl_nz)
                        begin
                            step_fwd        = 1'b1;
                            steps_left_next = sl_dec;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
                PH_MOVE:
                begin
                    if (sl_nz)
                    begin
                        step_fwd        = 1'b1;
                        steps_left_next = sl_dec;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    step_fwd = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (zero_pat)
        begin
            pattern_next = '0;
        end
        else if (step_fwd)
        begin
            pattern_next = pattern_reg + PAT_W'(1);
        end
        else if (step_bwd)
        begin
            pattern_next = pattern_reg - PAT_W'(1);
        end
        else
        begin
            pattern_next = pattern_reg;
        end
        coil_next = (zero_pat || step_fwd || step_bwd) ? coil_pattern(pattern_next) : coil_reg;
    end

    always_comb
    begin
        res.coils         = coil_next;
        res.stepped       = step_fwd || step_bwd;
        res.busy_res      = phase_next != PH_IDLE;
        res.is_calibrated = done_next;
        res.rev_count     = rev_steps_next;
        res.refused       = refused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pattern_reg    <= '0;
            coil_reg       <= '0;
            run_index_reg  <= '0;
            run_steps_reg  <= '0;
            run_total_reg  <= '0;
            steps_left_reg <= '0;
            rev_steps_reg  <= '0;
            slot_size_reg  <= '0;
            pend_slot_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            pattern_reg    <= pattern_next;
            coil_reg       <= coil_next;
            run_index_reg  <= run_index_next;
            run_steps_reg  <= run_steps_next;
            run_total_reg  <= run_total_next;
            steps_left_reg <= steps_left_next;
            rev_steps_reg  <= rev_steps_next;
            slot_size_reg  <= slot_size_next;
            pend_slot_reg  <= pend_slot_next;
            done_reg       <= done_next;
        end
    end

    `SHS_ASSERT_SAME(a_cmd_no_step, advance && item.kind != KIND_TICK, !res.stepped,
        "command item took a step")
    `SHS_ASSERT_SAME(a_refuse_cond, advance && res.refused,
        phase_reg == PH_IDLE && !done_reg && item.kind == KIND_RUN,
        "run refused while calibrated or busy")
    `SHS_ASSERT_SAME(a_idle_tick, advance && phase_reg == PH_IDLE && item.kind == KIND_TICK,
        !res.stepped && !res.busy_res, "idle tick changed the motor")
    `SHS_ASSERT_NEXT(a_cal_sticky, done_reg, done_reg, "calibrated flag was lost")
    `SHS_ASSERT_NEXT(a_coil_match, advance && res.stepped, coil_reg == coil_pattern(pattern_reg),
        "coil drive does not match the pattern index after a step")

endmodule

>>> design/shs_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequencer output stage
// Result register on the master side; packs the result item into tdata.
// ---------------------------------------------------------------------------
module shs_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  shs_pkg::result_t               res,
    output logic                           load_ok,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [shs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import shs_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [OUT_DATA_W-1:0] data_next;

    assign load_ok  = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    assign data_next = {res.refused, res.rev_count, res.is_calibrated,
                        res.busy_res, res.stepped, res.coils};

    always_comb
    begin
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> design/stepper_homing_sequencer_top.sv
`timescale 1ns / 1ps
// An item is held in the input register, resolved by combinational step logic
// and its result captured in the result register. Throughput: one item per
// cycle while the result register is free or being read by the receiver.
// Reset (rst_n low, asynchronous): idle, coils off, not calibrated, all
// counts zero, index_offset back to 150, both stages empty.
// ---------------------------------------------------------------------------
// Stepper homing sequencer top level
// Half-step stepper driver with index-sensor calibration and slot moves.
// ---------------------------------------------------------------------------
module stepper_homing_sequencer_top #(
    parameter int CAL_RUNS      = shs_pkg::CAL_RUNS_DEF,
    parameter int SLOTS_PER_REV = shs_pkg::SLOTS_PER_REV_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sensor [0], slots [8:1], pill_count [16:9], rev_steps [32:17], zero fill
    input  logic [shs_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind [1:0]
    input  logic [shs_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // coils [3:0], stepped [4], busy_res [5], is_calibrated [6],
    // rev_count [22:7], refused [23]
    output logic [shs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [shs_pkg::REV_W-1:0]      cfg_wdata
);
    import shs_pkg::*;

    logic             item_valid;
    item_t            item;
    result_t          res;
    logic             load_ok;
    logic             advance;
    logic [REV_W-1:0] index_offset_reg;

    assign advance = item_valid && load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_offset_reg <= INDEX_OFFSET_RST;
        end
        else if (cfg_we)
        begin
            index_offset_reg <= cfg_wdata;
        end
    end

    shs_in_stage #(
        .SLOTS_PER_REV (SLOTS_PER_REV)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    shs_core #(
        .CAL_RUNS      (CAL_RUNS),
        .SLOTS_PER_REV (SLOTS_PER_REV)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .item         (item),
        .index_offset (index_offset_reg),
        .res          (res)
    );

    shs_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .res      (res),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper homing sequencer testbench
// Sends tick and command transfers into the sequencer and checks every
// drive report against a cycle-free model of the step logic kept here.
// Opens with a short table of hand-picked items, then pushes one long
// index run to saturate the step counter, then runs random calibrate,
// reverse-calibrate and slot-move sequences with noise mixed in.
// Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
    import shs_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 29;
    localparam int RANDOM_ITEMS = 1250;
    localparam int MAX_REPORTS  = 10;

    localparam logic [COIL_W-1:0] HALF_STEP [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    typedef struct {
        kind_t             kind;
        logic              sensor;
        logic [7:0]        slots;
        logic [7:0]        pills;
        logic [REV_W-1:0]  rev;
        bit                typed;
        result_t           res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic [REV_W-1:0]      cfg_wdata;

    // Motor model state.
    phase_t                mdl_phase;
    logic [PAT_W-1:0]      mdl_pat;
    logic [COIL_W-1:0]     mdl_coils;
    logic [2:0]            mdl_run_idx;
    logic [15:0]           mdl_run_cnt;
    int unsigned           mdl_run_sum;
    logic [23:0]           mdl_left;
    logic [REV_W-1:0]      mdl_rev;
    logic                  mdl_cal;
    logic [REV_W-1:0]      mdl_offset;

    result_t drive_reports_q [$];
    int      mismatches;
    int      counted;
    int      cycles;
    bit      calm;
    bit      hold_req;

    stepper_homing_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL stepper_homing_sequencer_top");
            $finish;
        end
    end

    function automatic void half_step(input bit fwd);
        mdl_pat   = mdl_pat + (fwd ? 3'd1 : 3'd7);
        mdl_coils = HALF_STEP[mdl_pat];
    endfunction

    function automatic void bump_run_count();
        if (mdl_run_cnt != 16'hFFFF)
            mdl_run_cnt = mdl_run_cnt + 16'd1;
    endfunction

    function automatic logic [23:0] slot_move_steps(input logic [REV_W-1:0] rev,
                                                    input logic [7:0] n);
        int unsigned prod;
        prod = (int'(rev) / SLOTS_PER_REV_DEF) * int'(n);
        return prod[23:0];
    endfunction

    // Applies one item to the motor model and returns the drive report it causes.
    function automatic result_t motor_step(input kind_t k, input logic sensor,
                                           input logic [7:0] slots, input logic [7:0] pills,
                                           input logic [REV_W-1:0] rsteps);
        result_t     r;
        bit          acted;
        int unsigned avg;
        int          i;
        r = '0;
        if (k != KIND_TICK)
        begin
            if (mdl_phase == PH_IDLE)
            begin
                if (k == KIND_CAL)
                begin
                    mdl_phase   = PH_ALIGN_HI;
                    mdl_run_idx = '0;
                    mdl_run_cnt = '0;
                    mdl_run_sum = 0;
                end
                else if (k == KIND_REV_CAL)
                begin
                    mdl_phase   = PH_BACK;
                    mdl_run_sum = rsteps;
                    mdl_left    = slot_move_steps(rsteps, pills);
                end
                else if (mdl_cal)
                begin
                    mdl_phase = PH_MOVE;
                    mdl_left  = slot_move_steps(mdl_rev, slots);
                end
                else
                begin
                    r.refused = 1'b1;
                end
            end
        end
        else
        begin
            // A failed wait moves on and looks at the same sensor sample again.
            acted = 1'b0;
            for (i = 0; i < 4 && !acted; i++)
            begin
                case (mdl_phase)
                    PH_ALIGN_HI:
                        if (sensor)
                        begin
                            half_step(1'b1);
                            r.stepped = 1'b1;
                            acted = 1'b1;
                        end
                        else
                            mdl_phase = PH_ALIGN_LO;
                    PH_ALIGN_LO:
                        if (!sensor)
                        begin
                            half_step(1'b1);
                            r.stepped = 1'b1;
                            acted = 1'b1;
                        end
                        else
                            mdl_phase = PH_RUN_HI;
                    PH_RUN_HI:
                        if (sensor)
                        begin
                            half_step(1'b1);
                            bump_run_count();
                            r.stepped = 1'b1;
                            acted = 1'b1;
                        end
                        else
                            mdl_phase = PH_RUN_LO;
                    PH_RUN_LO:
                        if (!sensor)
                        begin
                            half_step(1'b1);
                            bump_run_count();
                            r.stepped = 1'b1;
                            acted = 1'b1;
                        end
                        else
                        begin
                            // The first run only aligns; it is left out of the average.
                            if (mdl_run_idx > 0)
                            begin
                                mdl_run_sum = mdl_run_sum + mdl_run_cnt;
                                if (mdl_run_sum > 32'h7FFFF)
                                    mdl_run_sum = 32'h7FFFF;
                            end
                            mdl_run_cnt = '0;
                            if (mdl_run_idx >= CAL_RUNS_DEF - 1)
                            begin
                                avg = mdl_run_sum / (CAL_RUNS_DEF - 1);
                                if (avg > REV_MAX)
                                    avg = REV_MAX;
                                mdl_rev     = avg[15:0];
                                mdl_left    = (avg > mdl_offset) ? avg - mdl_offset : 0;
                                mdl_run_idx = '0;
                                mdl_phase   = PH_EXTRA;
                            end
                            else
                            begin
                                mdl_run_idx = mdl_run_idx + 3'd1;
                                mdl_phase   = PH_RUN_HI;
                            end
                        end
                    PH_EXTRA:
                    begin
                        if (mdl_left > 0)
                        begin
                            half_step(1'b1);
                            mdl_left  = mdl_left - 24'd1;
                            r.stepped = 1'b1;
                        end
                        else
                        begin
                            mdl_pat   = '0;
                            mdl_coils = HALF_STEP[0];
                            mdl_cal   = 1'b1;
                            mdl_phase = PH_IDLE;
                        end
                        acted = 1'b1;
                    end
                    PH_BACK:
                        if (sensor)
                        begin
                            half_step(1'b0);
                            r.stepped = 1'b1;
                            acted = 1'b1;
                        end
                        else
                        begin
                            mdl_rev     = mdl_run_sum[15:0];
                            mdl_run_sum = 0;
                            mdl_phase   = PH_MOVE;
                        end
                    PH_MOVE:
                    begin
                        if (mdl_left > 0)
                        begin
                            half_step(1'b1);
                            mdl_left  = mdl_left - 24'd1;
                            r.stepped = 1'b1;
                        end
                        else
                        begin
                            mdl_cal   = 1'b1;
                            mdl_phase = PH_IDLE;
                        end
                        acted = 1'b1;
                    end
                    default:
                        acted = 1'b1;
                endcase
            end
        end
        r.coils         = mdl_coils;
        r.busy_res      = (mdl_phase != PH_IDLE);
        r.is_calibrated = mdl_cal;
        r.rev_count     = mdl_rev;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input kind_t k, input logic s, input logic [7:0] sl,
                                         input logic [7:0] pc, input logic [15:0] rv,
                                         input bit typed, input logic [3:0] c,
                                         input logic st, input logic b, input logic cal,
                                         input logic [15:0] rc, input logic rf);
        stim_row_t row;
        row.kind   = k;
        row.sensor = s;
        row.slots  = sl;
        row.pills  = pc;
        row.rev    = rv;
        row.typed  = typed;
        row.res    = '{coils: c, stepped: st, busy_res: b, is_calibrated: cal,
                       rev_count: rc, refused: rf};
        return row;
    endfunction

    task automatic send_item(input kind_t k, input logic sensor, input logic [7:0] slots,
                             input logic [7:0] pills, input logic [REV_W-1:0] rsteps,
                             input bit typed, input result_t typed_res);
        result_t res;
        int      gap;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 3);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'd0, rsteps, pills, slots, sensor};
        do @(posedge clk); while (!s_tready);
        if (k != KIND_TICK || mdl_phase != PH_IDLE)
            counted++;
        res = motor_step(k, sensor, slots, pills, rsteps);
        drive_reports_q.push_back(typed ? typed_res : res);
    endtask

    task automatic tick(input logic sensor);
        send_item(KIND_TICK, sensor, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 1'b0, '0);
    endtask

    task automatic random_command();
        send_item(kind_t'($urandom_range(1, 3)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 1'b0, '0);
    endtask

    // Ticks with random sensor levels, and an ignored command now and then,
    // until the sequence in progress has finished.
    task automatic drain_motion();
        while (mdl_phase != PH_IDLE)
        begin
            if ($urandom_range(99) < 8)
                random_command();
            else
                tick(1'($urandom_range(1)));
        end
    endtask

    task automatic idle_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic set_offset(input logic [REV_W-1:0] value);
        drain_motion();
        idle_input();
        while (drive_reports_q.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mdl_offset = value;
    endtask

    task automatic cal_sequence();
        int k;
        send_item(KIND_CAL, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 16'($urandom_range(65535)), 1'b0, '0);
        repeat ($urandom_range(0, 4)) tick(1'b1);
        repeat ($urandom_range(1, 4)) tick(1'b0);
        for (k = 0; k < CAL_RUNS_DEF; k++)
        begin
            repeat ($urandom_range(0, 20)) tick(1'b1);
            repeat ($urandom_range(1, 20)) tick(1'b0);
        end
        tick(1'b1);
        drain_motion();
    endtask

    // Drive reports are checked at the rising edge against the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.coils         = m_tdata[3:0];
            got.stepped       = m_tdata[4];
            got.busy_res      = m_tdata[5];
            got.is_calibrated = m_tdata[6];
            got.rev_count     = m_tdata[22:7];
            got.refused       = m_tdata[23];
            if (drive_reports_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: transfer with nothing pending, data %h", m_tdata);
            end
            else
            begin
                want = drive_reports_q.pop_front();
                if (got.coils !== want.coils || got.stepped !== want.stepped ||
                    got.busy_res !== want.busy_res ||
                    got.is_calibrated !== want.is_calibrated ||
                    got.rev_count !== want.rev_count || got.refused !== want.refused)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp coils=%h stepped=%b busy=%b cal=%b ",
                                  "rev=%0d refused=%b, got coils=%h stepped=%b busy=%b ",
                                  "cal=%b rev=%0d refused=%b"},
                                 want.coils, want.stepped, want.busy_res,
                                 want.is_calibrated, want.rev_count, want.refused,
                                 got.coils, got.stepped, got.busy_res,
                                 got.is_calibrated, got.rev_count, got.refused);
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        stim_row_t dir_rows [$];
        bit        hold_done;
        int        pick;
        logic [15:0] rv;
        logic [7:0]  pc;
        logic [7:0]  sl;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        mismatches = 0;
        counted   = 0;
        cycles    = 0;

        mdl_phase   = PH_IDLE;
        mdl_pat     = '0;
        mdl_coils   = '0;
        mdl_run_idx = '0;
        mdl_run_cnt = '0;
        mdl_run_sum = 0;
        mdl_left    = '0;
        mdl_rev     = '0;
        mdl_cal     = 1'b0;
        mdl_offset  = INDEX_OFFSET_RST;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Idle tick, refused run, reverse calibrate with an empty move,
        // ignored command while busy, then a short calibration with no
        // extra steps due, then a long reverse-calibrate move.
        dir_rows.push_back(mk_row(KIND_TICK, 0, 8'd0, 8'd0, 16'd0,
                                  1, 4'h0, 0, 0, 0, 16'd0, 0));
        dir_rows.push_back(mk_row(KIND_RUN, 1, 8'd255, 8'd0, 16'd0,
                                  1, 4'h0, 0, 0, 0, 16'd0, 1));
        dir_rows.push_back(mk_row(KIND_TICK, 1, 8'd0, 8'd0, 16'd0,
                                  1, 4'h0, 0, 0, 0, 16'd0, 0));
        dir_rows.push_back(mk_row(KIND_REV_CAL, 1, 8'd0, 8'd0, 16'hFFFF,
                                  1, 4'h0, 0, 1, 0, 16'd0, 0));
        dir_rows.push_back(mk_row(KIND_TICK, 1, 8'd0, 8'd0, 16'd0,
                                  1, 4'h9, 1, 1, 0, 16'd0, 0));
        dir_rows.push_back(mk_row(KIND_CAL, 1, 8'hFF, 8'hFF, 16'hFFFF,
                                  1, 4'h9, 0, 1, 0, 16'd0, 0));
        dir_rows.push_back(mk_row(KIND_TICK, 0, 8'd0, 8'd0, 16'd0,
                                  1, 4'h9, 0, 0, 1, 16'hFFFF, 0));
        dir_rows.push_back(mk_row(KIND_RUN, 0, 8'd0, 8'd0, 16'd0,
                                  1, 4'h9, 0, 1, 1, 16'hFFFF, 0));
        dir_rows.push_back(mk_row(KIND_TICK, 1, 8'd0, 8'd0, 16'd0,
                                  1, 4'h9, 0, 0, 1, 16'hFFFF, 0));
        dir_rows.push_back(mk_row(KIND_CAL, 0, 8'd0, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
        repeat (4)
        begin
            dir_rows.push_back(mk_row(KIND_TICK, 1, 8'd0, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
            dir_rows.push_back(mk_row(KIND_TICK, 0, 8'd0, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
        end
        dir_rows.push_back(mk_row(KIND_TICK, 1, 8'd0, 8'd0, 16'd0,
                                  1, 4'h1, 0, 0, 1, 16'd2, 0));
        dir_rows.push_back(mk_row(KIND_REV_CAL, 1, 8'd0, 8'd255, 16'd16,
                                  0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_RUN, 1, 8'd3, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_TICK, 0, 8'd0, 8'd0, 16'd0, 0, 0, 0, 0, 0, 0, 0));

        foreach (dir_rows[i])
            send_item(dir_rows[i].kind, dir_rows[i].sensor, dir_rows[i].slots,
                      dir_rows[i].pills, dir_rows[i].rev, dir_rows[i].typed,
                      dir_rows[i].res);
        drain_motion();

        // One counted run longer than the step counter can hold, with the
        // largest offset so no extra advance follows.
        set_offset(16'hFFFF);
        calm = 1'b1;
        send_item(KIND_CAL, 1'b0, 8'd0, 8'd0, 16'd0, 1'b0, '0);
        tick(1'b0);
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        repeat (65600) tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        drain_motion();
        calm = 1'b0;
        send_item(KIND_REV_CAL, 1'b1, 8'd0, 8'd3, 16'd40, 1'b0, '0);
        drain_motion();
        set_offset(16'd0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted >= 300 && !hold_done)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            calm = (counted >= 700 && counted < 850);
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                case ($urandom_range(4))
                    0:       set_offset(16'd0);
                    1:       set_offset(16'hFFFF);
                    2:       set_offset(INDEX_OFFSET_RST);
                    3:       set_offset(16'($urandom_range(65535)));
                    default: set_offset(16'($urandom_range(40)));
                endcase
            end
            else if (pick < 40)
                cal_sequence();
            else if (pick < 62)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    rv = 16'($urandom_range(65535));
                    pc = 8'($urandom_range(1));
                end
                else if (pick < 10)
                begin
                    rv = 16'($urandom_range(8, 23));
                    pc = 8'd255;
                end
                else
                begin
                    rv = 16'($urandom_range(100));
                    pc = 8'($urandom_range(20));
                end
                send_item(KIND_REV_CAL, 1'($urandom_range(1)), 8'($urandom_range(255)),
                          pc, rv, 1'b0, '0);
                repeat ($urandom_range(0, 6)) tick(1'b1);
                drain_motion();
            end
            else if (pick < 88)
            begin
                // Keep moves short once the revolution count is large.
                if (mdl_rev > 16'd1000)
                    sl = 8'($urandom_range(1));
                else if ($urandom_range(99) < 5)
                    sl = 8'd255;
                else
                    sl = 8'($urandom_range(8));
                send_item(KIND_RUN, 1'($urandom_range(1)), sl, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 1'b0, '0);
                drain_motion();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(1) == 0)
                        random_command();
                    else
                        tick(1'($urandom_range(1)));
                end
            end
        end
        calm = 1'b0;

        idle_input();
        while (drive_reports_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && drive_reports_q.size() == 0)
            $display("PASS stepper_homing_sequencer_top");
        else
            $display("FAIL stepper_homing_sequencer_top");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/shs_pkg.sv
design/shs_in_stage.sv
design/shs_core.sv
design/shs_out_stage.sv
design/stepper_homing_sequencer_top.sv
test/tb_top.sv
